>>> design/wfed_pkg.sv
package wfed_pkg;

  localparam int CFG_DATA_W = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int THRESH_W = 8;
  localparam int RATIO_W = 17;
  localparam int DIM_W = 12;
  localparam int CAPTURE_W = 16;
  localparam int WHITE_PIX_W = 23;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd200;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 17'd32768;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;
  localparam logic [DIM_W-1:0] ROWS_RESET = 12'd720;
  localparam logic [DIM_W-1:0] COLS_RESET = 12'd1280;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WHITE_THRESHOLD = 2'd0,
    REG_REGION_RATIO    = 2'd1,
    REG_FRAME_ROWS      = 2'd2,
    REG_FRAME_COLS      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                   last;
    logic                   frame_white;
    logic                   capture;
    logic [CAPTURE_W-1:0]   capture_number;
    logic [WHITE_PIX_W-1:0] white_pixels;
  } frame_res_t;

endpackage

>>> design/white_frame_edge_detector.sv
// A pixel word is registered at acceptance; if it ends a frame, its result is then loaded into
// the output register, which waits while an unread result is still held there.
// Throughput: one pixel word per cycle; the input stalls only while a finished result waits.
// The window registers take a register write at the same edge; the new frame size and window
// take effect at the next frame's first pixel. Reset is synchronous, active low, and clears all
// control state.
module white_frame_edge_detector #(
  parameter int MAX_ROWS = 2048,
  parameter int MAX_COLS = 2048
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             in_blue_level,
  input  logic [7:0]                             in_green_level,
  input  logic [7:0]                             in_red_level,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_frame_white,
  output logic                                   out_capture_previous,
  output logic [wfed_pkg::CAPTURE_W-1:0]         out_capture_number,
  output logic [wfed_pkg::WHITE_PIX_W-1:0]       out_white_pixels,
  input  logic                                   cfg_we,
  input  logic [wfed_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [wfed_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import wfed_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);

  logic                 s_valid_r, s_valid_nxt;
  logic [7:0]           s_blue_r, s_green_r, s_red_r;
  logic                 out_valid_r;
  frame_res_t           out_r;
  frame_res_t           res;
  logic                 out_free, s_go, in_take;
  logic [THRESH_W-1:0]  threshold;
  logic [RW-1:0]        pend_rows, pend_rc;
  logic [CW-1:0]        pend_cols, pend_cc;

  wfed_cfg #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .RW(RW),
    .CW(CW)
  ) u_cfg (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .threshold(threshold),
    .pend_rows(pend_rows),
    .pend_cols(pend_cols),
    .pend_rc(pend_rc),
    .pend_cc(pend_cc)
  );

  wfed_frame #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .RW(RW),
    .CW(CW)
  ) u_frame (
    .clk(clk),
    .rst_n(rst_n),
    .advance(s_go),
    .blue(s_blue_r),
    .green(s_green_r),
    .red(s_red_r),
    .threshold(threshold),
    .pend_rows(pend_rows),
    .pend_cols(pend_cols),
    .pend_rc(pend_rc),
    .pend_cc(pend_cc),
    .res(res)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s_go     = s_valid_r && (!res.last || out_free);
  assign in_ready = !s_valid_r || s_go;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_take) begin
      s_valid_nxt = 1'b1;
    end else if (s_go) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
      if (s_go && res.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_blue_r  <= in_blue_level;
      s_green_r <= in_green_level;
      s_red_r   <= in_red_level;
    end
    if (s_go && res.last) begin
      out_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_frame_white      = out_r.frame_white;
  assign out_capture_previous = out_r.capture;
  assign out_capture_number   = out_r.capture_number;
  assign out_white_pixels     = out_r.white_pixels;

  a_capture_needs_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.capture || out_r.frame_white))
    else $error("Capture flagged on a frame that is not white.");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s_valid_r))
    else $error("Pipeline holds a word after reset.");

  a_stalled_end_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid_r && res.last && out_valid_r && !out_ready) |=> s_valid_r)
    else $error("Frame-ending word left the stage while the output was full.");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s_go && res.last) |=> out_valid_r)
    else $error("Frame result was not presented.");

endmodule

>>> design/wfed_cfg.sv
module wfed_cfg #(
  parameter int MAX_ROWS = 2048,
  parameter int MAX_COLS = 2048,
  parameter int RW = $clog2(MAX_ROWS + 1),
  parameter int CW = $clog2(MAX_COLS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wfed_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wfed_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic [wfed_pkg::THRESH_W-1:0]       threshold,
  output logic [RW-1:0]                       pend_rows,
  output logic [CW-1:0]                       pend_cols,
  output logic [RW-1:0]                       pend_rc,
  output logic [CW-1:0]                       pend_cc
);
  import wfed_pkg::*;

  localparam int RCMP_W = (RW > DIM_W) ? RW : DIM_W;
  localparam int CCMP_W = (CW > DIM_W) ? CW : DIM_W;

  logic [THRESH_W-1:0] thresh_r, thresh_nxt;
  logic [RATIO_W-1:0]  ratio_r, ratio_nxt;
  logic [DIM_W-1:0]    rows_r, rows_nxt;
  logic [DIM_W-1:0]    cols_r, cols_nxt;

  logic [RATIO_W-1:0]  ratio_cl;
  logic [RW-1:0]       rows_cl;
  logic [CW-1:0]       cols_cl;
  logic [RW+16:0]      row_prod;
  logic [CW+16:0]      col_prod;

  logic [RW-1:0] p_rows_r, p_rc_r;
  logic [CW-1:0] p_cols_r, p_cc_r;

  // Reset is folded into the next-state values so that the window registers
  // below always match the register contents.
  always_comb begin
    thresh_nxt = thresh_r;
    ratio_nxt  = ratio_r;
    rows_nxt   = rows_r;
    cols_nxt   = cols_r;
    if (!rst_n) begin
      thresh_nxt = THRESH_RESET;
      ratio_nxt  = RATIO_RESET;
      rows_nxt   = ROWS_RESET;
      cols_nxt   = COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WHITE_THRESHOLD: thresh_nxt = cfg_wdata[THRESH_W-1:0];
        REG_REGION_RATIO:    ratio_nxt  = cfg_wdata[RATIO_W-1:0];
        REG_FRAME_ROWS:      rows_nxt   = cfg_wdata[DIM_W-1:0];
        REG_FRAME_COLS:      cols_nxt   = cfg_wdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ratio_cl = (ratio_nxt > RATIO_ONE) ? RATIO_ONE : ratio_nxt;
    if (rows_nxt == '0) begin
      rows_cl = RW'(1);
    end else if (RCMP_W'(rows_nxt) > RCMP_W'(MAX_ROWS)) begin
      rows_cl = RW'(MAX_ROWS);
    end else begin
      rows_cl = RW'(rows_nxt);
    end
    if (cols_nxt == '0) begin
      cols_cl = CW'(1);
    end else if (CCMP_W'(cols_nxt) > CCMP_W'(MAX_COLS)) begin
      cols_cl = CW'(MAX_COLS);
    end else begin
      cols_cl = CW'(cols_nxt);
    end
  end

  assign row_prod = (RW+17)'(rows_cl) * (RW+17)'(ratio_cl);
  assign col_prod = (CW+17)'(cols_cl) * (CW+17)'(ratio_cl);

  always_ff @(posedge clk) begin
    thresh_r <= thresh_nxt;
    ratio_r  <= ratio_nxt;
    rows_r   <= rows_nxt;
    cols_r   <= cols_nxt;
    p_rows_r <= rows_cl;
    p_cols_r <= cols_cl;
    p_rc_r   <= RW'(row_prod >> 16);
    p_cc_r   <= CW'(col_prod >> 16);
  end

  assign threshold = thresh_r;
  assign pend_rows = p_rows_r;
  assign pend_cols = p_cols_r;
  assign pend_rc   = p_rc_r;
  assign pend_cc   = p_cc_r;

endmodule

>>> design/wfed_frame.sv
module wfed_frame #(
  parameter int MAX_ROWS = 2048,
  parameter int MAX_COLS = 2048,
  parameter int RW = $clog2(MAX_ROWS + 1),
  parameter int CW = $clog2(MAX_COLS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic [7:0]                    blue,
  input  logic [7:0]                    green,
  input  logic [7:0]                    red,
  input  logic [wfed_pkg::THRESH_W-1:0] threshold,
  input  logic [RW-1:0]                 pend_rows,
  input  logic [CW-1:0]                 pend_cols,
  input  logic [RW-1:0]                 pend_rc,
  input  logic [CW-1:0]                 pend_cc,
  output wfed_pkg::frame_res_t          res
);
  import wfed_pkg::*;

  localparam int TW = $clog2(MAX_ROWS * MAX_COLS + 1);

  logic [RW-1:0] row_r, rows_r, rs_r, re_r;
  logic [CW-1:0] col_r, cols_r, cs_r, ce_r;
  logic [TW-1:0] area_r, tally_r;
  logic          last_white_r, have_prev_r;
  logic [CAPTURE_W-1:0] cap_cnt_r;

  logic          first;
  logic [RW-1:0] p_rs, p_re, rows_e, rs_e, re_e;
  logic [CW-1:0] p_cs, p_ce, cols_e, cs_e, ce_e;
  logic          in_win, white_px, col_last, row_last, frame_last;
  logic [TW-1:0] tally_new, area_use;
  logic [TW+2:0] lhs, rhs;
  logic          white, capture;
  logic [CAPTURE_W-1:0] cap_num;

  assign first = (row_r == '0) && (col_r == '0);

  assign p_rs = (pend_rows - pend_rc) >> 1;
  assign p_re = p_rs + pend_rc;
  assign p_cs = (pend_cols - pend_cc) >> 1;
  assign p_ce = p_cs + pend_cc;

  assign rows_e = first ? pend_rows : rows_r;
  assign cols_e = first ? pend_cols : cols_r;
  assign rs_e   = first ? p_rs : rs_r;
  assign re_e   = first ? p_re : re_r;
  assign cs_e   = first ? p_cs : cs_r;
  assign ce_e   = first ? p_ce : ce_r;

  assign in_win = (row_r >= rs_e) && (row_r < re_e) && (col_r >= cs_e) && (col_r < ce_e);
  assign white_px = (blue > threshold) && (green > threshold) && (red > threshold);
  assign tally_new = (first ? '0 : tally_r) + TW'(in_win && white_px);

  assign col_last   = ((CW+1)'(col_r) + (CW+1)'(1)) >= (CW+1)'(cols_e);
  assign row_last   = ((RW+1)'(row_r) + (RW+1)'(1)) >= (RW+1)'(rows_e);
  assign frame_last = col_last && row_last;

  // A frame of a single pixel ends before area_r can follow the new window.
  assign area_use = first ? TW'(pend_rc[0] & pend_cc[0]) : area_r;
  assign lhs = (TW+3)'(tally_new) + ((TW+3)'(tally_new) << 2);
  assign rhs = (TW+3)'(area_use) << 2;
  assign white = lhs > rhs;
  assign capture = have_prev_r && !last_white_r && white;
  assign cap_num = cap_cnt_r + CAPTURE_W'(capture);

  always_comb begin
    res.last           = frame_last;
    res.frame_white    = white;
    res.capture        = capture;
    res.capture_number = cap_num;
    res.white_pixels   = WHITE_PIX_W'(tally_new);
  end

  always_ff @(posedge clk) begin
    if (advance && first) begin
      rows_r <= pend_rows;
      cols_r <= pend_cols;
      rs_r   <= p_rs;
      re_r   <= p_re;
      cs_r   <= p_cs;
      ce_r   <= p_ce;
      area_r <= TW'((RW+CW)'(pend_rc) * (RW+CW)'(pend_cc));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      col_r        <= '0;
      tally_r      <= '0;
      last_white_r <= 1'b0;
      have_prev_r  <= 1'b0;
      cap_cnt_r    <= '0;
    end else if (advance) begin
      tally_r <= tally_new;
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
      if (frame_last) begin
        last_white_r <= white;
        have_prev_r  <= 1'b1;
        cap_cnt_r    <= cap_num;
      end
    end
  end

endmodule

>>> tb/sv/white_frame_edge_detector_tb.sv
module white_frame_edge_detector_tb;
  import wfed_pkg::*;

  localparam int RANDOM_PIXELS = 700;
  localparam int QUIET_FROM = 600;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic                   frame_white;
    logic                   capture_previous;
    logic [CAPTURE_W-1:0]   capture_number;
    logic [WHITE_PIX_W-1:0] white_pixels;
  } frame_verdict_t;

  class frame_scoreboard;
    logic [THRESH_W-1:0] threshold;
    logic [RATIO_W-1:0] ratio;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    int row_pos;
    int col_pos;
    int rows_used;
    int cols_used;
    int row_lo;
    int row_hi;
    int col_lo;
    int col_hi;
    int unsigned tally;
    bit prev_white;
    bit seen_frame;
    logic [CAPTURE_W-1:0] captures;
    frame_verdict_t verdicts[$];
    int errors;

    function new();
      threshold = THRESH_RESET;
      ratio = RATIO_RESET;
      rows_reg = ROWS_RESET;
      cols_reg = COLS_RESET;
      row_pos = 0;
      col_pos = 0;
      tally = 0;
      prev_white = 1'b0;
      seen_frame = 1'b0;
      captures = '0;
      errors = 0;
      latch_window();
    endfunction

    function int clamp_dim(int v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void latch_window();
      longint ratio_c;
      longint rc;
      longint cc;
      ratio_c = (ratio > RATIO_ONE) ? longint'(RATIO_ONE) : longint'(ratio);
      rows_used = clamp_dim(int'(rows_reg), 2048);
      cols_used = clamp_dim(int'(cols_reg), 2048);
      rc = (longint'(rows_used) * ratio_c) >> 16;
      cc = (longint'(cols_used) * ratio_c) >> 16;
      row_lo = (rows_used - int'(rc)) / 2;
      row_hi = row_lo + int'(rc);
      col_lo = (cols_used - int'(cc)) / 2;
      col_hi = col_lo + int'(cc);
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_WHITE_THRESHOLD: threshold = val[THRESH_W-1:0];
        REG_REGION_RATIO:    ratio = val[RATIO_W-1:0];
        REG_FRAME_ROWS:      rows_reg = val[DIM_W-1:0];
        REG_FRAME_COLS:      cols_reg = val[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      longint area;
      bit white;
      bit capture;
      frame_verdict_t v;
      if (row_pos == 0 && col_pos == 0) begin
        latch_window();
        tally = 0;
      end
      if (row_pos >= row_lo && row_pos < row_hi && col_pos >= col_lo && col_pos < col_hi &&
          b > threshold && g > threshold && r > threshold)
        tally++;
      if (col_pos + 1 < cols_used) begin
        col_pos++;
        return;
      end
      col_pos = 0;
      if (row_pos + 1 < rows_used) begin
        row_pos++;
        return;
      end
      row_pos = 0;
      area = longint'(row_hi - row_lo) * longint'(col_hi - col_lo);
      white = (longint'(tally) * 5) > (area * 4);
      capture = seen_frame && !prev_white && white;
      if (capture) captures++;
      v.frame_white = white;
      v.capture_previous = capture;
      v.capture_number = captures;
      v.white_pixels = tally[WHITE_PIX_W-1:0];
      verdicts = {verdicts, v};
      prev_white = white;
      seen_frame = 1'b1;
      tally = 0;
    endfunction

    task report_mismatch(string line);
      $display("MISMATCH: %s", line);
      errors++;
    endtask

    task check_result(logic fw, logic cap, logic [CAPTURE_W-1:0] num,
                      logic [WHITE_PIX_W-1:0] pix);
      frame_verdict_t v;
      if (verdicts.size() == 0) begin
        report_mismatch("frame result with no finished frame pending");
        return;
      end
      v = verdicts.pop_front();
      if (fw !== v.frame_white)
        report_mismatch($sformatf("frame_white got %0d want %0d", fw, v.frame_white));
      if (cap !== v.capture_previous)
        report_mismatch($sformatf("capture_previous got %0d want %0d", cap,
                                  v.capture_previous));
      if (num !== v.capture_number)
        report_mismatch($sformatf("capture_number got %0d want %0d", num, v.capture_number));
      if (pix !== v.white_pixels)
        report_mismatch($sformatf("white_pixels got %0d want %0d", pix, v.white_pixels));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_blue_level = '0;
  logic [7:0] in_green_level = '0;
  logic [7:0] in_red_level = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic out_frame_white;
  logic out_capture_previous;
  logic [CAPTURE_W-1:0] out_capture_number;
  logic [WHITE_PIX_W-1:0] out_white_pixels;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  frame_scoreboard frames = new();
  int cycle_count = 0;
  int in_gap_odds = 0;
  int out_stall_odds = 0;
  int stall_left = 0;

  white_frame_edge_detector dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_blue_level        (in_blue_level),
    .in_green_level       (in_green_level),
    .in_red_level         (in_red_level),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_frame_white      (out_frame_white),
    .out_capture_previous (out_capture_previous),
    .out_capture_number   (out_capture_number),
    .out_white_pixels     (out_white_pixels),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_stall_odds == 0) begin
      stall_left <= 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(1, out_stall_odds) == 1) begin
      stall_left <= int'($urandom_range(1, 18)) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      frames.check_result(out_frame_white, out_capture_previous, out_capture_number,
                          out_white_pixels);
  end

  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue_level <= b;
    in_green_level <= g;
    in_red_level <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames.note_pixel(b, g, r);
  endtask

  // The sender holds off until every finished frame has been read out.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(logic [7:0] thr, logic [16:0] ratio, logic [11:0] rows,
                              logic [11:0] cols);
    cfg_reg_t order [4];
    logic [CFG_DATA_W-1:0] vals [4];
    order = '{REG_WHITE_THRESHOLD, REG_REGION_RATIO, REG_FRAME_ROWS, REG_FRAME_COLS};
    vals = '{CFG_DATA_W'(thr), CFG_DATA_W'(ratio), CFG_DATA_W'(rows), CFG_DATA_W'(cols)};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      frames.write_reg(order[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] make_pixel(int share, logic [7:0] thr);
    logic [7:0] c [3];
    int lo;
    lo = int'(thr) + 1;
    if (thr != 8'd255 && $urandom_range(0, 99) < share) begin
      for (int i = 0; i < 3; i++) c[i] = 8'($urandom_range(lo, 255));
    end else if ($urandom_range(0, 3) == 0 && thr != 8'd255) begin
      for (int i = 0; i < 3; i++) c[i] = 8'($urandom_range(lo, 255));
      c[$urandom_range(0, 2)] = thr;
    end else begin
      for (int i = 0; i < 3; i++) c[i] = 8'($urandom_range(0, 255));
    end
    return {c[2], c[1], c[0]};
  endfunction

  task automatic send_frames(int count, int share, logic [7:0] thr);
    logic [23:0] px;
    for (int k = 0; k < count; k++) begin
      px = make_pixel(share, thr);
      send_pixel(px[7:0], px[15:8], px[23:16]);
    end
  endtask

  initial begin : stimulus
    int random_count;
    int frame_count;
    int frame_size;
    int extra;
    int share;
    int pick;
    logic [7:0] thr;
    logic [16:0] ratio;
    logic [11:0] rows;
    logic [11:0] cols;
    int shares [4];

    shares = '{0, 30, 85, 100};
    random_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_gap_odds = 3;
    out_stall_odds = 3;

    apply_config(8'd200, 17'd65536, 12'd2, 12'd2);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd201, 8'd201, 8'd201);
    send_pixel(8'd200, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd200, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd201);
    send_pixel(8'd201, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd201, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    settle_block();
    // A ratio above whole and a zero frame size give a single-pixel window.
    apply_config(8'd200, 17'd131071, 12'd0, 12'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    settle_block();
    apply_config(8'd0, 17'd0, 12'd1, 12'd3);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    settle_block();
    apply_config(8'd255, 17'd65536, 12'd1, 12'd2);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    settle_block();
    apply_config(8'd0, 17'd65536, 12'd1, 12'd1);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd0, 8'd255, 8'd255);
    settle_block();

    while (random_count < RANDOM_PIXELS) begin
      if (random_count >= QUIET_FROM) begin
        in_gap_odds = 0;
        out_stall_odds = 0;
      end else begin
        pick = $urandom_range(0, 2);
        in_gap_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 10;
        pick = $urandom_range(0, 2);
        out_stall_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 10;
      end
      case ($urandom_range(0, 4))
        0: thr = 8'd0;
        1: thr = 8'd255;
        2: thr = 8'($urandom_range(0, 255));
        default: thr = 8'($urandom_range(128, 230));
      endcase
      case ($urandom_range(0, 5))
        0: ratio = 17'd0;
        1: ratio = 17'd65536;
        2: ratio = 17'd131071;
        3: ratio = 17'($urandom_range(0, 131071));
        default: ratio = 17'($urandom_range(16384, 60000));
      endcase
      pick = $urandom_range(0, 11);
      rows = (pick == 0) ? 12'd0 : (pick == 1) ? 12'($urandom_range(20, 40)) :
             12'($urandom_range(1, 6));
      pick = $urandom_range(0, 11);
      cols = (pick == 0) ? 12'd0 : 12'($urandom_range(1, 10));
      settle_block();
      apply_config(thr, ratio, rows, cols);
      frame_size = frames.clamp_dim(int'(rows), 2048) * frames.clamp_dim(int'(cols), 2048);
      frame_count = $urandom_range(1, 6);
      if (frame_count * frame_size > RANDOM_PIXELS - random_count)
        frame_count = (RANDOM_PIXELS - random_count) / frame_size + 1;
      // A ragged tail leaves a frame open so the next register writes land mid-frame.
      extra = ($urandom_range(0, 3) == 0 && frame_size > 1) ? $urandom_range(1, frame_size - 1)
                                                           : 0;
      for (int f = 0; f < frame_count; f++) begin
        share = shares[$urandom_range(0, 3)];
        send_frames(frame_size, share, thr);
        random_count += frame_size;
      end
      if (extra > 0) begin
        send_frames(extra, shares[$urandom_range(0, 3)], thr);
        random_count += extra;
      end
    end

    settle_block();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (frames.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

>>> white_frame_edge_detector.f
design/wfed_pkg.sv
design/wfed_cfg.sv
design/wfed_frame.sv
design/white_frame_edge_detector.sv
tb/sv/white_frame_edge_detector_tb.sv
